FILE: design/mdf_pkg.sv
// ----------------------------------------------------------------------------
// mdf_pkg
// Shared widths, codes, queue entry types and compare helpers for the
// 3x3 median filter with level counts.
// ----------------------------------------------------------------------------
package mdf_pkg;

    localparam int PIX_W        = 8;
    localparam int SIZE_W       = 11;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int TOTAL_W      = 21;
    localparam int NTAPS        = 9;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);
    localparam int DEF_MAX_SIZE = 1024;
    localparam int SIZE_RESET   = 8;
    localparam logic [PIX_W-1:0] BRIGHT_RESET = PIX_W'(200);
    localparam logic [PIX_W-1:0] DARK_RESET   = PIX_W'(50);

    typedef logic [PIX_W-1:0] t_pix;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_SIZE = 2'd0,
        CFG_BRIGHT_THR = 2'd1,
        CFG_DARK_THR   = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        LVL_DARK   = 2'd0,
        LVL_NORMAL = 2'd1,
        LVL_BRIGHT = 2'd2
    } t_level;

    typedef struct packed {
        logic [NTAPS-1:0][PIX_W-1:0] tap;
        logic                        frame_end;
    } t_qent;

    typedef struct packed {
        logic  valid;
        t_qent ent;
    } t_qpush;

    function automatic t_pix min2(input t_pix a, input t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pix max2(input t_pix a, input t_pix b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_pix min3(input t_pix a, input t_pix b, input t_pix c);
        return min2(min2(a, b), c);
    endfunction

    function automatic t_pix max3(input t_pix a, input t_pix b, input t_pix c);
        return max2(max2(a, b), c);
    endfunction

    function automatic t_pix med3(input t_pix a, input t_pix b, input t_pix c);
        t_pix lo;
        t_pix hi;
        lo = min2(a, b);
        hi = max2(a, b);
        return max2(lo, min2(hi, c));
    endfunction

endpackage

FILE: design/median3x3_filter_with_level_counts.sv
// ----------------------------------------------------------------------------
// median3x3_filter_with_level_counts
// Path: the request completing a neighbourhood feeds the front register, queue,
//   s1-s3 and output register; results trail pixels by n+1 requests.
// Throughput: one request per cycle when the queue has room, via one read and one
//   line buffer write per request (same-address write forwarded into the next read).
// Reset: synchronous, clears position, queue and pipeline valids; size 8,
//   thresholds 200/50; line buffer contents are kept, no clearing pass.
// ----------------------------------------------------------------------------
module median3x3_filter_with_level_counts
    import mdf_pkg::*;
#(
    parameter int MAX_SIZE = DEF_MAX_SIZE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_action,
    input  logic [PIX_W-1:0]      i_pixel,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIX_W-1:0]      o_median,
    output logic [1:0]            o_level_class,
    output logic [TOTAL_W-1:0]    o_bright_total,
    output logic [TOTAL_W-1:0]    o_dark_total,
    output logic [TOTAL_W-1:0]    o_normal_total,
    output logic                  o_frame_end
);

    localparam int N_W     = $clog2(MAX_SIZE + 1);
    localparam int SZ_W    = (N_W > SIZE_W) ? N_W : SIZE_W;
    localparam int RESET_N = (SIZE_RESET > MAX_SIZE) ? MAX_SIZE : SIZE_RESET;

    logic [N_W-1:0]    r_size, n_size;
    t_pix              r_bright_thr, n_bright_thr;
    t_pix              r_dark_thr, n_dark_thr;

    logic              cfg_write, restart;
    logic [SZ_W-1:0]   size_x;
    logic [N_W-1:0]    size_clamped;
    t_qpush            push;
    t_qent             head;
    logic              q_empty, pop;
    logic [QCNT_W-1:0] q_level;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign restart     = cfg_write && (i_cfg_index == CFG_IMAGE_SIZE);

    always_comb begin
        size_x = SZ_W'(i_cfg_data[SIZE_W-1:0]);
        if (size_x == '0) begin
            size_clamped = N_W'(1);
        end else if (size_x > SZ_W'(MAX_SIZE)) begin
            size_clamped = N_W'(MAX_SIZE);
        end else begin
            size_clamped = N_W'(size_x);
        end

        n_size       = r_size;
        n_bright_thr = r_bright_thr;
        n_dark_thr   = r_dark_thr;
        if (cfg_write) begin
            unique case (i_cfg_index)
                CFG_IMAGE_SIZE: n_size       = size_clamped;
                CFG_BRIGHT_THR: n_bright_thr = i_cfg_data[PIX_W-1:0];
                CFG_DARK_THR:   n_dark_thr   = i_cfg_data[PIX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size       <= N_W'(RESET_N);
            r_bright_thr <= BRIGHT_RESET;
            r_dark_thr   <= DARK_RESET;
        end else begin
            r_size       <= n_size;
            r_bright_thr <= n_bright_thr;
            r_dark_thr   <= n_dark_thr;
        end
    end

    mdf_front #(
        .MAX_SIZE (MAX_SIZE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_action),
        .i_pixel    (i_pixel),
        .i_size     (r_size),
        .i_restart  (restart),
        .i_q_level  (q_level),
        .o_push     (push)
    );

    mdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_level (q_level)
    );

    mdf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_restart      (restart),
        .i_bright_thr   (r_bright_thr),
        .i_dark_thr     (r_dark_thr),
        .i_head         (head),
        .i_empty        (q_empty),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_median       (o_median),
        .o_level_class  (o_level_class),
        .o_bright_total (o_bright_total),
        .o_dark_total   (o_dark_total),
        .o_normal_total (o_normal_total),
        .o_frame_end    (o_frame_end)
    );

endmodule

FILE: design/mdf_front.sv
// ----------------------------------------------------------------------------
// mdf_front
// Tracks the raster position, drops early flush requests, keeps the line
// buffer and the 3x3 window, and pushes zero-padded neighbourhoods.
// ----------------------------------------------------------------------------
module mdf_front
    import mdf_pkg::*;
#(
    parameter int MAX_SIZE = DEF_MAX_SIZE
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_action,
    input  logic [PIX_W-1:0]              i_pixel,
    input  logic [$clog2(MAX_SIZE+1)-1:0] i_size,
    input  logic                          i_restart,
    input  logic [QCNT_W-1:0]             i_q_level,
    output t_qpush                        o_push
);

    localparam int COL_W = $clog2(MAX_SIZE);
    localparam int N_W   = $clog2(MAX_SIZE + 1);
    localparam int ROW_W = $clog2(MAX_SIZE + 2);
    localparam int CW    = ROW_W + 1;

    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic               r_f1_valid;
    logic [COL_W-1:0]   r_f1_col;
    t_pix               r_f1_pix;
    logic [NTAPS-1:0]   r_f1_mask;
    logic               r_f1_have;
    logic               r_f1_fe;
    logic               r_f1_fwd;
    logic [2*PIX_W-1:0] r_f1_fwd_data;
    logic [2*PIX_W-1:0] r_rd;
    logic [2*PIX_W-1:0] r_line_mem [MAX_SIZE];
    t_pix [2:0][2:0]    r_win, n_win;

    logic [CW-1:0]      row_x, size_x, k;
    logic [N_W-1:0]     col_inc;
    logic               col0, draining, drop, accept, step, frame_end, have;
    logic [2:0]         row_ok, col_ok;
    logic [NTAPS-1:0]   mask;
    t_pix               pix;
    logic [2*PIX_W-1:0] line, wdata;

    assign o_in_ready = (i_q_level + QCNT_W'(r_f1_valid)) < QCNT_W'(QDEPTH);

    always_comb begin
        row_x    = CW'(r_row);
        size_x   = CW'(i_size);
        col0     = (r_col == '0);
        draining = row_x >= size_x;
        drop     = !draining && i_action;
        accept   = i_in_valid && o_in_ready;
        step     = accept && !drop;
        pix      = draining ? '0 : i_pixel;
        k        = '0;
        for (int r = 0; r < 3; r++) begin
            k         = CW'(2 - r) + CW'(col0);
            row_ok[r] = (row_x >= k) && (row_x < size_x + k);
        end
        col_ok[0] = col0 ? (size_x >= CW'(2)) : (r_col >= COL_W'(2));
        col_ok[1] = 1'b1;
        col_ok[2] = !col0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                mask[r*3+c] = row_ok[r] && col_ok[c];
            end
        end
        have      = row_ok[1];
        frame_end = col0 && (row_x == size_x + CW'(1));
        col_inc   = N_W'(r_col) + N_W'(1);

        n_col = r_col;
        n_row = r_row;
        if (step) begin
            if (frame_end) begin
                n_col = '0;
                n_row = '0;
            end else if (col_inc >= i_size) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = COL_W'(col_inc);
            end
        end
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_f1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_f1_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_f1_col      <= r_col;
            r_f1_pix      <= pix;
            r_f1_mask     <= mask;
            r_f1_have     <= have;
            r_f1_fe       <= frame_end;
            r_f1_fwd      <= r_f1_valid && (r_f1_col == r_col);
            r_f1_fwd_data <= wdata;
        end
    end

    // line buffer entry: {two rows up, one row up}
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_rd <= r_line_mem[r_col];
        end
        if (r_f1_valid) begin
            r_line_mem[r_f1_col] <= wdata;
        end
    end

    always_comb begin
        line = r_f1_fwd ? r_f1_fwd_data : r_rd;
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = line[2*PIX_W-1:PIX_W];
        n_win[1][2] = line[PIX_W-1:0];
        n_win[2][2] = r_f1_pix;
        wdata       = {line[PIX_W-1:0], r_f1_pix};
    end

    always_ff @(posedge i_clk) begin
        if (r_f1_valid) begin
            r_win <= n_win;
        end
    end

    always_comb begin
        o_push               = '0;
        o_push.valid         = r_f1_valid && r_f1_have;
        o_push.ent.frame_end = r_f1_fe;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                o_push.ent.tap[r*3+c] = r_f1_mask[r*3+c] ? n_win[r][c] : '0;
            end
        end
    end

    a_fe_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f1_valid && r_f1_fe |-> r_f1_have)
        else $error("frame end on an item without a result");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        row_x <= size_x + CW'(1))
        else $error("row position beyond the drain rows");

endmodule

FILE: design/mdf_queue.sv
// ----------------------------------------------------------------------------
// mdf_queue
// Short queue of neighbourhoods between the front and the sorting back end.
// ----------------------------------------------------------------------------
module mdf_queue
    import mdf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_qpush            i_push,
    input  logic              i_pop,
    output t_qent             o_head,
    output logic              o_empty,
    output logic [QCNT_W-1:0] o_level
);

    t_qent             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            if (i_push.valid) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            r_level <= r_level + QCNT_W'(i_push.valid) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.ent;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_level == '0);
    assign o_level = r_level;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> (r_level != QCNT_W'(QDEPTH)) || i_pop)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");

endmodule

FILE: design/mdf_back.sv
// ----------------------------------------------------------------------------
// mdf_back
// Median of nine through a three-stage compare network, level classing,
// per-frame class totals and the output register.
// ----------------------------------------------------------------------------
module mdf_back
    import mdf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_restart,
    input  logic [PIX_W-1:0]   i_bright_thr,
    input  logic [PIX_W-1:0]   i_dark_thr,
    input  t_qent              i_head,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [PIX_W-1:0]   o_median,
    output logic [1:0]         o_level_class,
    output logic [TOTAL_W-1:0] o_bright_total,
    output logic [TOTAL_W-1:0] o_dark_total,
    output logic [TOTAL_W-1:0] o_normal_total,
    output logic               o_frame_end
);

    logic               r_v1, r_v2, r_v3, r_out_valid;
    t_pix [2:0]         r_s1_lo, r_s1_md, r_s1_hi;
    logic               r_s1_fe;
    t_pix               r_s2_lo, r_s2_md, r_s2_hi;
    logic               r_s2_fe;
    t_pix               r_s3_med;
    logic               r_s3_fe;
    t_pix               r_med;
    t_level             r_cls;
    logic               r_fe;
    logic [TOTAL_W-1:0] r_bright, r_dark, r_normal;
    logic               r_clr;

    logic               en;
    t_pix [2:0]         s1_lo, s1_md, s1_hi;
    t_level             cls;
    logic [TOTAL_W-1:0] base_b, base_d, base_n;

    assign en    = !r_out_valid || i_out_ready;
    assign o_pop = en && !i_empty;

    always_comb begin
        for (int g = 0; g < 3; g++) begin
            s1_lo[g] = min3(i_head.tap[g*3], i_head.tap[g*3+1], i_head.tap[g*3+2]);
            s1_md[g] = med3(i_head.tap[g*3], i_head.tap[g*3+1], i_head.tap[g*3+2]);
            s1_hi[g] = max3(i_head.tap[g*3], i_head.tap[g*3+1], i_head.tap[g*3+2]);
        end
        if (r_s3_med > i_bright_thr) begin
            cls = LVL_BRIGHT;
        end else if (r_s3_med < i_dark_thr) begin
            cls = LVL_DARK;
        end else begin
            cls = LVL_NORMAL;
        end
        base_b = r_clr ? '0 : r_bright;
        base_d = r_clr ? '0 : r_dark;
        base_n = r_clr ? '0 : r_normal;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
            r_clr       <= 1'b1;
        end else begin
            if (en) begin
                r_v1        <= o_pop;
                r_v2        <= r_v1;
                r_v3        <= r_v2;
                r_out_valid <= r_v3;
                if (r_v3) begin
                    r_clr <= r_s3_fe;
                end
            end
            if (i_restart) begin
                r_clr <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_lo  <= s1_lo;
            r_s1_md  <= s1_md;
            r_s1_hi  <= s1_hi;
            r_s1_fe  <= i_head.frame_end;
            r_s2_lo  <= max3(r_s1_lo[0], r_s1_lo[1], r_s1_lo[2]);
            r_s2_md  <= med3(r_s1_md[0], r_s1_md[1], r_s1_md[2]);
            r_s2_hi  <= min3(r_s1_hi[0], r_s1_hi[1], r_s1_hi[2]);
            r_s2_fe  <= r_s1_fe;
            r_s3_med <= med3(r_s2_lo, r_s2_md, r_s2_hi);
            r_s3_fe  <= r_s2_fe;
            if (r_v3) begin
                r_med    <= r_s3_med;
                r_cls    <= cls;
                r_fe     <= r_s3_fe;
                r_bright <= base_b + TOTAL_W'(cls == LVL_BRIGHT);
                r_dark   <= base_d + TOTAL_W'(cls == LVL_DARK);
                r_normal <= base_n + TOTAL_W'(cls == LVL_NORMAL);
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_median       = r_med;
    assign o_level_class  = r_cls;
    assign o_bright_total = r_bright;
    assign o_dark_total   = r_dark;
    assign o_normal_total = r_normal;
    assign o_frame_end    = r_fe;

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// Median filter testbench
// Drives square frames, flush requests, ignored requests and register writes
// into the 3x3 median filter. A scoreboard tracks the line buffers, window and
// class totals, and compares every result with the oldest prediction. Both
// handshakes stall at random.
// ----------------------------------------------------------------------------
module testbench
    import mdf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int ITEM_TARGET    = 1200;
    localparam int SETTLE_CYCLES  = 20;
    localparam int QUIET_LIMIT    = 5000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        t_pix               median;
        t_level             level;
        logic [TOTAL_W-1:0] bright_total;
        logic [TOTAL_W-1:0] dark_total;
        logic [TOTAL_W-1:0] normal_total;
        logic               frame_end;
    } t_median_result;

    class median_level_board;
        logic [SIZE_W-1:0]  image_size;
        t_pix               bright_thr;
        t_pix               dark_thr;
        t_pix               upper_line [DEF_MAX_SIZE];
        t_pix               lower_line [DEF_MAX_SIZE];
        t_pix               win [3][3];
        int                 row;
        int                 col;
        logic [TOTAL_W-1:0] sent;
        logic [TOTAL_W-1:0] bright_cnt;
        logic [TOTAL_W-1:0] dark_cnt;
        logic [TOTAL_W-1:0] normal_cnt;
        t_median_result     expected_medians [$];
        int unsigned        consumed;
        int unsigned        errors;

        function new();
            foreach (upper_line[i]) begin
                upper_line[i] = '0;
                lower_line[i] = '0;
            end
            image_size = SIZE_W'(SIZE_RESET);
            bright_thr = BRIGHT_RESET;
            dark_thr   = DARK_RESET;
            consumed   = 0;
            errors     = 0;
            restart();
        endfunction

        function void restart();
            row        = 0;
            col        = 0;
            sent       = '0;
            bright_cnt = '0;
            dark_cnt   = '0;
            normal_cnt = '0;
            foreach (win[r, c]) win[r][c] = '0;
        endfunction

        function int side();
            int s;
            s = image_size;
            if (s < 1) s = 1;
            if (s > DEF_MAX_SIZE) s = DEF_MAX_SIZE;
            return s;
        endfunction

        function int pending();
            return expected_medians.size();
        endfunction

        function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IMAGE_SIZE: begin
                    image_size = data;
                    restart();
                end
                CFG_BRIGHT_THR: bright_thr = data[PIX_W-1:0];
                CFG_DARK_THR:   dark_thr = data[PIX_W-1:0];
                default: ;
            endcase
        endfunction

        function t_pix window_median(int tr, int tc, int centre, int n);
            t_pix v [$];
            int   dr;
            int   dc;
            int   y;
            int   x;
            int   idx;
            for (dr = -1; dr <= 1; dr++) begin
                for (dc = -1; dc <= 1; dc++) begin
                    y   = tr + dr;
                    x   = tc + dc;
                    idx = centre + dc;
                    if (y >= 0 && y < n && x >= 0 && x < n && idx >= 0 && idx <= 2)
                        v.push_back(win[dr + 1][idx]);
                    else
                        v.push_back('0);
                end
            end
            v.sort();
            return v[4];
        endfunction

        function void shift_in(int c, t_pix p);
            for (int r = 0; r < 3; r++) begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2]     = upper_line[c];
            win[1][2]     = lower_line[c];
            win[2][2]     = p;
            upper_line[c] = lower_line[c];
            lower_line[c] = p;
        endfunction

        function void note_request(logic act, t_pix pixel);
            int             n;
            int             r;
            int             c;
            int             tr;
            int             tc;
            int             centre;
            bit             have;
            t_pix           pv;
            t_pix           med;
            t_median_result res;
            n = side();
            r = row;
            c = col;
            // flush while the frame is still filling: dropped
            if (r < n && act == ACT_FLUSH) return;
            consumed++;
            pv  = (r >= n) ? '0 : pixel;
            med = '0;
            if (c >= DEF_MAX_SIZE) c = 0;
            if (c == 0) begin
                tr     = r - 2;
                tc     = n - 1;
                centre = 2;
            end else begin
                shift_in(c, pv);
                tr     = r - 1;
                tc     = c - 1;
                centre = 1;
            end
            have = (tr >= 0 && tr < n);
            if (have) med = window_median(tr, tc, centre, n);
            if (c == 0) shift_in(c, pv);
            c++;
            if (c >= n) begin
                c = 0;
                r++;
            end
            col = c;
            row = r & 'h7FF;
            if (!have) return;
            res.median = med;
            if (med > bright_thr) begin
                res.level = LVL_BRIGHT;
                bright_cnt++;
            end else if (med < dark_thr) begin
                res.level = LVL_DARK;
                dark_cnt++;
            end else begin
                res.level = LVL_NORMAL;
                normal_cnt++;
            end
            sent++;
            res.bright_total = bright_cnt;
            res.dark_total   = dark_cnt;
            res.normal_total = normal_cnt;
            res.frame_end    = (sent >= n * n);
            expected_medians.push_back(res);
            if (res.frame_end) restart();
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
        endfunction

        function string show(t_median_result m);
            return $sformatf("med %0d cls %0d b %0d d %0d n %0d end %0b", m.median,
                             m.level, m.bright_total, m.dark_total, m.normal_total,
                             m.frame_end);
        endfunction

        function void check_result(t_median_result got);
            t_median_result want;
            if (expected_medians.size() == 0) begin
                flag({"unexpected result: ", show(got)});
                return;
            end
            want = expected_medians.pop_front();
            if (got.median !== want.median || got.level !== want.level ||
                got.bright_total !== want.bright_total ||
                got.dark_total !== want.dark_total ||
                got.normal_total !== want.normal_total ||
                got.frame_end !== want.frame_end)
                flag({"mismatch: expected ", show(want), ", actual ", show(got)});
        endfunction

        function void close();
            if (expected_medians.size() != 0) begin
                $display("%0d results never arrived", expected_medians.size());
                errors += expected_medians.size();
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_action;
    logic [PIX_W-1:0]      i_pixel;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [PIX_W-1:0]      o_median;
    logic [1:0]            o_level_class;
    logic [TOTAL_W-1:0]    o_bright_total;
    logic [TOTAL_W-1:0]    o_dark_total;
    logic [TOTAL_W-1:0]    o_normal_total;
    logic                  o_frame_end;

    median_level_board board;
    int unsigned       quiet_cycles = 0;
    int unsigned       burst_left = 0;
    int unsigned       stall_mode = 0;
    int unsigned       stall_left = 0;
    int unsigned       stall_phase = 0;

    median3x3_filter_with_level_counts i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_pixel        (i_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_median       (o_median),
        .o_level_class  (o_level_class),
        .o_bright_total (o_bright_total),
        .o_dark_total   (o_dark_total),
        .o_normal_total (o_normal_total),
        .o_frame_end    (o_frame_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 300);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= $urandom_range(0, 1);
            2: i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= (stall_phase % 3 != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_median_result got;
        bit             moved;
        moved = 0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                board.configure(i_cfg_index, i_cfg_data);
                moved = 1;
            end
            if (i_in_valid && o_in_ready) begin
                board.note_request(i_action, i_pixel);
                moved = 1;
            end
            if (o_out_valid && i_out_ready) begin
                got.median       = o_median;
                got.level        = t_level'(o_level_class);
                got.bright_total = o_bright_total;
                got.dark_total   = o_dark_total;
                got.normal_total = o_normal_total;
                got.frame_end    = o_frame_end;
                board.check_result(got);
                moved = 1;
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic t_pix pick_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return t_pix'($urandom_range(0, 63));
            4: return t_pix'($urandom_range(192, 255));
            default: return t_pix'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_pix pick_threshold();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return t_pix'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_request(input logic act, input t_pix pix);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_pixel    <= pix;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic drop_config_valid();
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int                    side;
        int                    stop_at;
        int                    k;
        int unsigned           target;
        bit                    need_size;
        logic [CFG_DATA_W-1:0] size_val;
        logic [CFG_DATA_W-1:0] big_sizes [1];

        board = new();
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_action    <= ACT_PIXEL;
        i_pixel     <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero size acts as one; early flush dropped, late pixel acts as flush
        write_register(CFG_IMAGE_SIZE, '0);
        write_register(CFG_BRIGHT_THR, 11'd254);
        write_register(CFG_DARK_THR, 11'd255);
        drop_config_valid();
        send_request(ACT_FLUSH, 8'h00);
        send_request(ACT_PIXEL, 8'hFF);
        send_request(ACT_PIXEL, 8'h55);
        send_request(ACT_FLUSH, 8'hAA);

        settle();
        write_register(CFG_IMAGE_SIZE, 11'd3);
        drop_config_valid();
        for (k = 0; k < 9; k++)
            send_request(ACT_PIXEL, (k == 4) ? 8'h80 : ((k % 3 == 0) ? 8'h00 : 8'hFF));
        for (k = 0; k < 4; k++)
            send_request(k[0] ? ACT_PIXEL : ACT_FLUSH, 8'h33);

        // abandon a frame part way, then restart it with a size write
        settle();
        write_register(CFG_IMAGE_SIZE, 11'd5);
        write_register(CFG_BRIGHT_THR, 11'd255);
        write_register(CFG_DARK_THR, 11'd0);
        drop_config_valid();
        send_request(ACT_PIXEL, 8'h01);
        send_request(ACT_PIXEL, 8'hFE);
        send_request(ACT_FLUSH, 8'h7F);
        send_request(ACT_PIXEL, 8'h10);
        settle();
        write_register(CFG_UNUSED, '1);
        write_register(CFG_IMAGE_SIZE, 11'd1);
        drop_config_valid();
        send_request(ACT_PIXEL, 8'hFE);
        send_request(ACT_FLUSH, 8'h00);
        send_request(ACT_PIXEL, 8'h7F);

        // widest frame: one full line plus a little, then abandon
        big_sizes[0] = '1;
        foreach (big_sizes[b]) begin
            settle();
            write_register(CFG_IMAGE_SIZE, big_sizes[b]);
            write_register(CFG_BRIGHT_THR, CFG_DATA_W'(pick_threshold()));
            write_register(CFG_DARK_THR, CFG_DATA_W'(pick_threshold()));
            drop_config_valid();
            repeat (DEF_MAX_SIZE + 40) send_request(ACT_PIXEL, pick_pixel());
        end

        need_size = 1;
        side      = 1;
        target    = board.consumed + ITEM_TARGET / 4;
        while (board.consumed < target) begin
            if (need_size || $urandom_range(0, 2) == 0) begin
                settle();
                if (need_size || $urandom_range(0, 1)) begin
                    case ($urandom_range(0, 19))
                        0: size_val = '0;
                        1, 2: size_val = CFG_DATA_W'($urandom_range(13, 20));
                        3, 4, 5, 6, 7: size_val = CFG_DATA_W'($urandom_range(7, 12));
                        default: size_val = CFG_DATA_W'($urandom_range(1, 6));
                    endcase
                    write_register(CFG_IMAGE_SIZE, size_val);
                    side = (size_val == 0) ? 1 : size_val;
                end
                if ($urandom_range(0, 1))
                    write_register(CFG_BRIGHT_THR, CFG_DATA_W'(pick_threshold()));
                if ($urandom_range(0, 1))
                    write_register(CFG_DARK_THR, CFG_DATA_W'(pick_threshold()));
                if ($urandom_range(0, 19) == 0)
                    write_register(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 2047)));
                drop_config_valid();
                need_size = 0;
            end
            stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, side * side - 1)
                                                  : side * side;
            k = 0;
            while (k < stop_at) begin
                if ($urandom_range(0, 15) == 0) begin
                    send_request(ACT_FLUSH, t_pix'($urandom_range(0, 255)));
                end else begin
                    send_request(ACT_PIXEL, pick_pixel());
                    k++;
                end
            end
            if (stop_at < side * side) begin
                need_size = 1;
            end else begin
                repeat (side + 1)
                    send_request(($urandom_range(0, 3) != 0) ? ACT_FLUSH : ACT_PIXEL,
                                 t_pix'($urandom_range(0, 255)));
            end
        end

        settle();
        board.close();
        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
